// ===== sv/atev_pkg.sv =====
// Shared constants, the model mode type and elaboration-time helpers
// for the atmospheric transmittance evaluation unit.
// No dependencies.
package atev_pkg;

  localparam logic [16:0] Q16_ONE       = 17'd65536;
  localparam logic [15:0] Q88_ONE       = 16'd256;
  localparam logic [31:0] LN2_Q32       = 32'd2977044472;
  localparam logic [32:0] LOG2E_Q32     = 33'd6196328019;
  localparam logic [36:0] LOG_FLOOR_Q32 = 37'd89005749036;
  localparam logic [25:0] K_MAX         = 26'h3FFFFFF;
  localparam logic [31:0] PEN_MAX       = 32'hFFFFFFFF;

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int LATENCY = 59;

  typedef enum logic [1:0] {
    MODE_BASIC = 2'd0,
    MODE_HUMID = 2'd1,
    MODE_ADAPT = 2'd2
  } mode_e;

  // Bitwise integer square root, used only on constants.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Root for bit idx of the fraction: 2^32 * 2^(-2^-idx), built by repeated roots.
  function automatic logic [31:0] exp_root(input int idx);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int k = 1; k <= idx; k++) begin
      r = isqrt64(r << 32);
    end
    return r[31:0];
  endfunction

endpackage

// ===== sv/atmospheric_transmittance_eval_unit.sv =====
// Top level of the atmospheric transmittance evaluation unit.
// Depends on atev_pkg, atev_delay, atev_cdiv, atev_log2 and atev_exp2.
//
// Usage: an evaluation is a transfer on the command channel. It is taken at a
// rising edge where start_i is high and busy_o is low. busy_o is always low,
// so a new evaluation can be started in every cycle.
// Each result appears on the result ports for exactly one cycle with done_o
// high, and results leave in issue order.
// Throughput is one evaluation per cycle. The latency is set mostly by the
// 32 squaring stages of the log2 unit and the 16 root-multiply stages of the
// exp unit; the constant dividers add three stages each.
// The receiver cannot stall the result channel, so there is no back-pressure
// and nothing inside ever waits.
// model_mode is written with model_mode_we_i; the user must do so only while
// no evaluation is in flight, as the block itself has no check for this.
// Reset (rst_ni low, asynchronous) clears all valid bits in the pipeline and
// sets model_mode to basic; evaluations in flight are dropped.
module atmospheric_transmittance_eval_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [16:0] base_transmit_i,
  input  logic [16:0] cloud_ratio_i,
  input  logic [19:0] path_metres_i,
  input  logic [15:0] aerosol_factor_i,
  input  logic [15:0] turbulence_i,
  input  logic        model_mode_we_i,
  input  logic [1:0]  model_mode_wdata_i,
  output logic        done_o,
  output logic [25:0] extinction_per_metre_o,
  output logic [16:0] transmit_out_o,
  output logic [31:0] penalty_scale_o
);

  // Humidity weights folded onto a common divisor of 3125.
  localparam logic [12:0] HUM_W_BASIC = 13'd5120;
  localparam logic [12:0] HUM_W_HUMID = 13'd7680;
  localparam logic [12:0] HUM_W_ADAPT = 13'd6144;

  logic [1:0] mode_q;

  // Input capture with clamping.
  logic        s0_vld_q;
  logic [16:0] bt0_q, cr0_q;
  logic [19:0] len0_q;
  logic [15:0] af0_q, tf0_q;

  // Second stage forms the path-turbulence product for the penalty.
  logic        s1_vld_q;
  logic [16:0] cr1_q;
  logic [19:0] len1_q;
  logic [15:0] af1_q, tf1_q;
  logic [35:0] lt1_q;

  logic        log_vld;
  logic [36:0] log_nats;

  logic [104:0] sd_dat;
  logic [16:0]  sd_cr;
  logic [15:0]  sd_af, sd_tf;
  logic [19:0]  sd_len;
  logic [35:0]  sd_lt;

  // Numerator stage.
  logic        nv_q;
  logic [36:0] base_n_q;
  logic [28:0] hum_n_q;
  logic [34:0] aer_n_q;
  logic [36:0] turb_n_q;
  logic [18:0] p1_n_q;
  logic [39:0] p2_n_q;
  logic [16:0] crn_q;
  logic [19:0] lenn_q;

  logic        dv;
  logic [36:0] base_q;
  logic [28:0] hum_q;
  logic [34:0] aer_q;
  logic [36:0] turb_q;
  logic [18:0] p1_q;
  logic [39:0] p2_q;
  logic [36:0] cl_dat;

  logic [27:0] ksum;
  logic [32:0] psum;
  logic [31:0] pen_d;

  logic        kv_q;
  logic [25:0] k_q;
  logic [31:0] pen_q;
  logic [19:0] lenk_q;

  logic        xv_q;
  logic [45:0] x_q;

  logic [57:0] kp_dat;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'(atev_pkg::MODE_BASIC);
    end else if (model_mode_we_i) begin
      mode_q <= model_mode_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      nv_q     <= 1'b0;
      kv_q     <= 1'b0;
      xv_q     <= 1'b0;
    end else begin
      s0_vld_q <= start_i && !busy_o;
      s1_vld_q <= s0_vld_q;
      nv_q     <= log_vld;
      kv_q     <= dv;
      xv_q     <= kv_q;
    end
  end

  // Ratios above one count as one; Q8.8 factors below one count as one.
  always_ff @(posedge clk_i) begin
    bt0_q  <= (base_transmit_i > atev_pkg::Q16_ONE) ? atev_pkg::Q16_ONE : base_transmit_i;
    cr0_q  <= (cloud_ratio_i > atev_pkg::Q16_ONE) ? atev_pkg::Q16_ONE : cloud_ratio_i;
    len0_q <= path_metres_i;
    af0_q  <= (aerosol_factor_i < atev_pkg::Q88_ONE) ? atev_pkg::Q88_ONE : aerosol_factor_i;
    tf0_q  <= (turbulence_i < atev_pkg::Q88_ONE) ? atev_pkg::Q88_ONE : turbulence_i;

    cr1_q  <= cr0_q;
    len1_q <= len0_q;
    af1_q  <= af0_q;
    tf1_q  <= tf0_q;
    lt1_q  <= 36'(len0_q) * 36'(tf0_q);
  end

  atev_log2 u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s0_vld_q),
    .tr_i   (bt0_q),
    .vld_o  (log_vld),
    .nats_o (log_nats)
  );

  // Side fields wait for the log unit.
  atev_delay #(.W(105), .N(33)) u_side_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s1_vld_q),
    .dat_i  ({cr1_q, af1_q, tf1_q, len1_q, lt1_q}),
    .vld_o  (),
    .dat_o  (sd_dat)
  );

  assign {sd_cr, sd_af, sd_tf, sd_len, sd_lt} = sd_dat;

  // All numerators are registered here so the dividers see clean inputs.
  always_ff @(posedge clk_i) begin
    base_n_q <= log_nats;
    case (mode_q)
      2'(atev_pkg::MODE_HUMID): hum_n_q <= 29'(sd_cr) * 29'(HUM_W_HUMID);
      2'(atev_pkg::MODE_ADAPT): hum_n_q <= 29'(sd_cr) * 29'(HUM_W_ADAPT);
      default:                  hum_n_q <= 29'(sd_cr) * 29'(HUM_W_BASIC);
    endcase
    aer_n_q  <= {sd_af - atev_pkg::Q88_ONE, 19'd0};
    turb_n_q <= {sd_tf - atev_pkg::Q88_ONE, 21'd0};
    p1_n_q   <= {1'b0, sd_cr, 1'b0} + 19'(sd_cr);
    p2_n_q   <= {sd_lt, 4'd0};
    crn_q    <= sd_cr;
    lenn_q   <= sd_len;
  end

  atev_cdiv #(.NW(37), .D(5000)) u_div_base (
    .clk_i (clk_i), .rst_ni (rst_ni), .vld_i (nv_q), .num_i (base_n_q),
    .vld_o (dv), .quo_o (base_q)
  );

  atev_cdiv #(.NW(29), .D(3125)) u_div_hum (
    .clk_i (clk_i), .rst_ni (rst_ni), .vld_i (nv_q), .num_i (hum_n_q),
    .vld_o (), .quo_o (hum_q)
  );

  atev_cdiv #(.NW(35), .D(3125)) u_div_aer (
    .clk_i (clk_i), .rst_ni (rst_ni), .vld_i (nv_q), .num_i (aer_n_q),
    .vld_o (), .quo_o (aer_q)
  );

  atev_cdiv #(.NW(37), .D(15625)) u_div_turb (
    .clk_i (clk_i), .rst_ni (rst_ni), .vld_i (nv_q), .num_i (turb_n_q),
    .vld_o (), .quo_o (turb_q)
  );

  atev_cdiv #(.NW(19), .D(10)) u_div_pen1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .vld_i (nv_q), .num_i (p1_n_q),
    .vld_o (), .quo_o (p1_q)
  );

  atev_cdiv #(.NW(40), .D(3125)) u_div_pen2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .vld_i (nv_q), .num_i (p2_n_q),
    .vld_o (), .quo_o (p2_q)
  );

  atev_delay #(.W(37), .N(3)) u_cl_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (nv_q),
    .dat_i  ({crn_q, lenn_q}),
    .vld_o  (),
    .dat_o  (cl_dat)
  );

  // Extinction sum and penalty scale. Mode 3 falls into the basic arm.
  always_comb begin
    ksum = 28'(base_q[24:0]) + 28'(hum_q[17:0]);
    psum = 33'(atev_pkg::Q16_ONE);
    case (mode_q)
      2'(atev_pkg::MODE_HUMID): begin
        ksum = ksum + 28'(aer_q[23:0]);
        psum = 33'(atev_pkg::Q16_ONE) + 33'(cl_dat[36:21]);
      end
      2'(atev_pkg::MODE_ADAPT): begin
        ksum = ksum + 28'(aer_q[23:0]) + 28'(turb_q[23:0]);
        psum = 33'(atev_pkg::Q16_ONE) + 33'(p1_q[15:0]) + 33'(p2_q[28:0]);
      end
      default: begin
        ksum = ksum;
      end
    endcase
    pen_d = psum[32] ? atev_pkg::PEN_MAX : psum[31:0];
  end

  always_ff @(posedge clk_i) begin
    k_q    <= (ksum > 28'(atev_pkg::K_MAX)) ? atev_pkg::K_MAX : ksum[25:0];
    pen_q  <= pen_d;
    lenk_q <= cl_dat[19:0];
    x_q    <= 46'(k_q) * 46'(lenk_q);
  end

  atev_exp2 u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (xv_q),
    .x_i    (x_q),
    .vld_o  (done_o),
    .tr_o   (transmit_out_o)
  );

  // Coefficient and penalty ride alongside the exp unit.
  atev_delay #(.W(58), .N(19)) u_kp_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (kv_q),
    .dat_i  ({k_q, pen_q}),
    .vld_o  (),
    .dat_o  (kp_dat)
  );

  assign extinction_per_metre_o = kp_dat[57:32];
  assign penalty_scale_o        = kp_dat[31:0];

endmodule

// ===== sv/atev_delay.sv =====
// Register delay line with a reset valid bit per stage.
// No dependencies.
module atev_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         vld_i,
  input  logic [W-1:0] dat_i,
  output logic         vld_o,
  output logic [W-1:0] dat_o
);

  logic [N-1:0] vld_q;
  logic [W-1:0] dat_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < N; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q[0] <= dat_i;
    for (int i = 1; i < N; i++) begin
      dat_q[i] <= dat_q[i-1];
    end
  end

  assign vld_o = vld_q[N-1];
  assign dat_o = dat_q[N-1];

endmodule

// ===== sv/atev_cdiv.sv =====
// Three-stage divider by a constant: reciprocal multiply in two halves,
// then one remainder check. No dependencies.
module atev_cdiv #(
  parameter int NW = 37,
  parameter int D  = 5000
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o
);

  localparam int H  = NW / 2;
  localparam int MW = NW - $clog2(D) + 1;
  localparam logic [MW-1:0] M = MW'((64'd1 << NW) / 64'(D));

  logic [2:0]          vld_q;
  logic [H+MW-1:0]     lo_q;
  logic [NW-H+MW-1:0]  hi_q;
  logic [NW-1:0]       n1_q, n2_q;
  logic [MW-1:0]       q0_q;
  logic [NW-1:0]       quo_q;
  logic [NW+MW-1:0]    sum;
  logic [NW-1:0]       qd, rem;

  // The truncated reciprocal undershoots by less than one, so the estimate
  // is the quotient or one below it.
  assign sum = {hi_q, {H{1'b0}}} + (NW+MW)'(lo_q);
  assign qd  = NW'(NW'(q0_q) * NW'(D));
  assign rem = n2_q - qd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= (H+MW)'(num_i[H-1:0]) * (H+MW)'(M);
    hi_q  <= (NW-H+MW)'(num_i[NW-1:H]) * (NW-H+MW)'(M);
    n1_q  <= num_i;
    q0_q  <= sum[NW+MW-1:NW];
    n2_q  <= n1_q;
    quo_q <= NW'(q0_q) + NW'(rem >= NW'(D));
  end

  assign vld_o = vld_q[2];
  assign quo_o = quo_q;

endmodule

// ===== sv/atev_log2.sv =====
// Pipelined -ln of a Q1.16 ratio in Q.32 nats: normalize, 32 squaring
// stages for the log2 fraction, then scale by ln2. Uses atev_pkg.
module atev_log2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  logic [16:0] tr_i,
  output logic        vld_o,
  output logic [36:0] nats_o
);

  typedef struct packed {
    logic [31:0] y;
    logic [31:0] f;
    logic [4:0]  e;
    logic        z;
  } lstage_t;

  lstage_t     st_q [33];
  lstage_t     st_d [33];
  logic [32:0] vld_q;
  logic        vld_out_q;
  logic [36:0] nats_q;

  logic [4:0]  e0;
  logic [47:0] sh0;
  logic [63:0] sq [33];
  logic [32:0] sqs [33];
  logic [36:0] lg, neg, nats;
  logic [63:0] plo;

  always_comb begin
    e0 = '0;
    for (int b = 0; b < 17; b++) begin
      if (tr_i[b]) e0 = 5'(b);
    end
    sh0 = {31'b0, tr_i} << (5'd31 - e0);
    st_d[0].y = sh0[31:0];
    st_d[0].f = '0;
    st_d[0].e = e0;
    st_d[0].z = (tr_i == '0);
    sq[0]  = '0;
    sqs[0] = '0;
    for (int i = 1; i < 33; i++) begin
      sq[i]  = 64'(st_q[i-1].y) * 64'(st_q[i-1].y);
      sqs[i] = sq[i][63:31];
      st_d[i].y = sqs[i][32] ? sqs[i][32:1] : sqs[i][31:0];
      st_d[i].f = {st_q[i-1].f[30:0], sqs[i][32]};
      st_d[i].e = st_q[i-1].e;
      st_d[i].z = st_q[i-1].z;
    end
  end

  assign lg   = {st_q[32].e, st_q[32].f};
  assign neg  = {5'd16, 32'd0} - lg;
  assign plo  = 64'(neg[31:0]) * 64'(atev_pkg::LN2_Q32);
  assign nats = 37'(neg[36:32]) * 37'(atev_pkg::LN2_Q32) + 37'(plo[63:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[31:0], vld_i};
      vld_out_q <= vld_q[32];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 33; i++) begin
      st_q[i] <= st_d[i];
    end
    nats_q <= st_q[32].z ? atev_pkg::LOG_FLOOR_Q32 : nats;
  end

  assign vld_o  = vld_out_q;
  assign nats_o = nats_q;

endmodule

// ===== sv/atev_exp2.sv =====
// Pipelined exp(-x) in Q1.16 for x in Q.32 nats: convert to base 2, one
// root multiply per upper fraction bit, then a rounding shift. Uses atev_pkg.
module atev_exp2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  logic [45:0] x_i,
  output logic        vld_o,
  output logic [16:0] tr_o
);

  typedef struct packed {
    logic [32:0] p;
    logic [31:0] f;
    logic [5:0]  n;
    logic        ov;
  } estage_t;

  estage_t     st_q [17];
  logic [32:0] pn [17];
  logic [16:0] vld_q;
  logic        vld_out_q;
  logic [16:0] tr_q;

  logic [61:0] yprod;
  logic [47:0] rsum, rsh;
  logic [16:0] res;

  assign yprod = 62'(x_i[36:8]) * 62'(atev_pkg::LOG2E_Q32);
  assign pn[0] = '0;

  for (genvar i = 1; i < 17; i++) begin : g_root
    localparam logic [31:0] R = atev_pkg::exp_root(i);
    logic [64:0] pr;
    assign pr    = 65'(st_q[i-1].p) * 65'(R);
    assign pn[i] = st_q[i-1].f[32-i] ? pr[64:32] : st_q[i-1].p;
  end

  assign rsum = 48'(st_q[16].p) + (48'd1 << (6'd15 + st_q[16].n));
  assign rsh  = rsum >> (6'd16 + st_q[16].n);
  assign res  = (st_q[16].ov || st_q[16].n > 6'd31) ? '0 : rsh[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[15:0], vld_i};
      vld_out_q <= vld_q[16];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0].p  <= 33'h1_0000_0000;
    st_q[0].f  <= yprod[55:24];
    st_q[0].n  <= yprod[61:56];
    st_q[0].ov <= (x_i[45:37] != '0);
    for (int i = 1; i < 17; i++) begin
      st_q[i].p  <= pn[i];
      st_q[i].f  <= st_q[i-1].f;
      st_q[i].n  <= st_q[i-1].n;
      st_q[i].ov <= st_q[i-1].ov;
    end
    tr_q <= res;
  end

  assign vld_o = vld_out_q;
  assign tr_o  = tr_q;

endmodule

// ===== sv/atev_checker.sv =====
// Port-level checks for the atmospheric transmittance evaluation unit,
// bound to its top level. Uses atev_pkg.
module atev_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [16:0] base_transmit_i,
  input logic [16:0] cloud_ratio_i,
  input logic [19:0] path_metres_i,
  input logic [15:0] aerosol_factor_i,
  input logic [15:0] turbulence_i,
  input logic        model_mode_we_i,
  input logic [1:0]  model_mode_wdata_i,
  input logic        done_o,
  input logic [25:0] extinction_per_metre_o,
  input logic [16:0] transmit_out_o,
  input logic [31:0] penalty_scale_o
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(atev_pkg::LATENCY) done_o)
    else $error("accepted transfer produced no result at the expected cycle");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, atev_pkg::LATENCY))
    else $error("result without a matching accepted transfer");

  a_transmit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> transmit_out_o <= 17'd65536)
    else $error("transmittance above one");

  a_penalty_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> penalty_scale_o >= 32'd65536)
    else $error("penalty scale below one");

  a_clear_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && extinction_per_metre_o == 26'd0) |-> transmit_out_o == 17'd65536)
    else $error("zero extinction must give full transmittance");

endmodule

bind atmospheric_transmittance_eval_unit atev_checker u_atev_checker (.*);
